// ----- design/ukv_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ukv_pkg;

    // Default table shape
    localparam int CAPACITY_DEF   = 16;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;

    // Port field widths
    localparam int ACTION_W   = 2;
    localparam int KEY_W      = 32;
    localparam int VALUE_W    = 32;
    localparam int POSITION_W = 4;
    localparam int STATUS_W   = 3;
    localparam int COUNT_W    = 5;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 48;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_ERASE  = 2'd1,
        ACT_LOOKUP = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_DUPLICATE    = 3'd1,
        ST_FULL         = 3'd2,
        ST_BAD_POSITION = 3'd3,
        ST_NOT_FOUND    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

// ----- design/ukv_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ukv_mem
    import ukv_pkg::*;
#(
    parameter int DEPTH      = CAPACITY_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    localparam int AW        = $clog2(DEPTH)
)(
    input  wire logic                  clk,
    input  wire logic                  wr_en,
    input  wire logic [AW-1:0]         wr_addr,
    input  wire logic [KEY_BITS-1:0]   wr_key,
    input  wire logic [VALUE_BITS-1:0] wr_value,
    input  wire logic [AW-1:0]         rd_addr,
    output logic      [KEY_BITS-1:0]   rd_key,
    output logic      [VALUE_BITS-1:0] rd_value
);

    logic [KEY_BITS-1:0]   key_mem   [DEPTH];
    logic [VALUE_BITS-1:0] value_mem [DEPTH];

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr]   <= wr_key;
            value_mem[wr_addr] <= wr_value;
        end
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        rd_key   <= key_mem[rd_addr];
        rd_value <= value_mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- design/unique_key_value_table.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Packed key/value table kept in insertion order.
// Input stream s_*: one request per item (insert, erase at position, lookup,
// clear). Output stream m_*: exactly one result per request, in order, with
// status, lookup hit and value, entry count and empty flag.
// Entries live in a memory with a registered read. Insert and lookup scan the
// entries one per cycle with the read pipelined against the compare, stopping
// early on a hit; an empty table is not scanned.
// Erase moves later entries down one per cycle through the same memory.
// Clear and a rejected erase go straight to the result state.
// One request is worked at a time; s_tready is high whenever the engine is
// idle, even while the previous result still sits in the output register.
// A finished result waits in its state until the output register is free,
// so a stalled receiver holds the engine after at most one more request.
// Reset empties the table at once (count cleared, no memory sweep) and
// drops any pending result; memory contents are never read past the count.

module unique_key_value_table
    import ukv_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // action[1:0], key[33:2], value[65:34], position[69:66], zero pad
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // status[2:0], found[3], found_value[35:4], entry_count[40:36],
    // is_empty[41], zero pad
    output logic      [OUT_DATA_W-1:0] m_tdata
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = CW + POSITION_W;

    // Unpack request
    logic [63:0]         in_key_ext;
    logic [63:0]         in_value_ext;
    action_t             in_action;
    logic [POSITION_W-1:0] in_position;

    assign in_action    = action_t'(s_tdata[1:0]);
    assign in_key_ext   = {32'd0, s_tdata[33:2]};
    assign in_value_ext = {32'd0, s_tdata[65:34]};
    assign in_position  = s_tdata[69:66];

    // Control and work registers
    state_t                 state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          idx_reg, idx_next;
    logic                   pend_reg, pend_next;
    logic [AW-1:0]          last_reg, last_next;
    logic                   hit_reg, hit_next;
    logic [VALUE_BITS-1:0]  hit_value_reg, hit_value_next;
    action_t                action_reg, action_next;
    logic [KEY_BITS-1:0]    key_reg, key_next;
    logic [VALUE_BITS-1:0]  value_reg, value_next;
    logic [POSITION_W-1:0]  pos_reg, pos_next;

    // Output register
    logic                   out_valid_reg, out_valid_next;
    status_t                out_status_reg, out_status_next;
    logic                   out_found_reg, out_found_next;
    logic [VALUE_W-1:0]     out_value_reg, out_value_next;
    logic [COUNT_W-1:0]     out_count_reg, out_count_next;
    logic                   out_empty_reg, out_empty_next;

    // Memory side
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [KEY_BITS-1:0]    wr_key;
    logic [VALUE_BITS-1:0]  wr_value;
    logic [AW-1:0]          rd_addr;
    logic [KEY_BITS-1:0]    rd_key;
    logic [VALUE_BITS-1:0]  rd_value;

    logic                   out_free;
    logic [XW-1:0]          pos_x;
    logic [XW-1:0]          in_pos_x;
    logic [XW-1:0]          count_x;
    logic [CW-1:0]          fin_count;
    logic [CW+COUNT_W-1:0]  fin_count_x;

    ukv_mem #(
        .DEPTH      (CAPACITY),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_mem (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_key   (wr_key),
        .wr_value (wr_value),
        .rd_addr  (rd_addr),
        .rd_key   (rd_key),
        .rd_value (rd_value)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign pos_x    = XW'(pos_reg);
    assign in_pos_x = XW'(in_position);
    assign count_x  = XW'(count_reg);
    assign rd_addr  = idx_reg[AW-1:0];
    assign s_tready = (state_reg == S_IDLE);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        last_reg       <= last_next;
        hit_reg        <= hit_next;
        hit_value_reg  <= hit_value_next;
        action_reg     <= action_next;
        key_reg        <= key_next;
        value_reg      <= value_next;
        pos_reg        <= pos_next;
        out_status_reg <= out_status_next;
        out_found_reg  <= out_found_next;
        out_value_reg  <= out_value_next;
        out_count_reg  <= out_count_next;
        out_empty_reg  <= out_empty_next;
    end

    // Sequencer: scan, shift, finish
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        pend_next       = pend_reg;
        last_next       = last_reg;
        hit_next        = hit_reg;
        hit_value_next  = hit_value_reg;
        action_next     = action_reg;
        key_next        = key_reg;
        value_next      = value_reg;
        pos_next        = pos_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_found_next  = out_found_reg;
        out_value_next  = out_value_reg;
        out_count_next  = out_count_reg;
        out_empty_next  = out_empty_reg;
        wr_en           = 1'b0;
        wr_addr         = last_reg - AW'(1);
        wr_key          = rd_key;
        wr_value        = rd_value;
        fin_count       = count_reg;
        fin_count_x     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                // Take a request
                if (s_tvalid)
                begin
                    action_next    = in_action;
                    key_next       = in_key_ext[KEY_BITS-1:0];
                    value_next     = in_value_ext[VALUE_BITS-1:0];
                    pos_next       = in_position;
                    hit_next       = 1'b0;
                    hit_value_next = '0;
                    pend_next      = 1'b0;
                    idx_next       = '0;
                    state_next     = S_DONE;
                    case (in_action) inside
                        ACT_INSERT, ACT_LOOKUP:
                        begin
                            if (count_reg != '0)
                                state_next = S_SCAN;
                        end
                        ACT_ERASE:
                        begin
                            if (in_pos_x < count_x)
                            begin
                                idx_next   = CW'(in_pos_x + XW'(1));
                                state_next = S_SHIFT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // Compare the entry read last cycle, issue the next read
                if (pend_reg && rd_key == key_reg)
                begin
                    hit_next       = 1'b1;
                    hit_value_next = rd_value;
                    pend_next      = 1'b0;
                    state_next     = S_DONE;
                end
                else if (idx_reg == count_reg)
                begin
                    pend_next  = 1'b0;
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next  = idx_reg + CW'(1);
                    pend_next = 1'b1;
                end
            end

            S_SHIFT:
            begin
                // Write the entry read last cycle one place down
                if (pend_reg)
                    wr_en = 1'b1;
                if (idx_reg < count_reg)
                begin
                    last_next = idx_reg[AW-1:0];
                    idx_next  = idx_reg + CW'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                        state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                // Commit and load the result once the output is free
                if (out_free)
                begin
                    out_status_next = ST_OK;
                    out_found_next  = 1'b0;
                    out_value_next  = '0;
                    case (action_reg)
                        ACT_INSERT:
                        begin
                            if (hit_reg)
                                out_status_next = ST_DUPLICATE;
                            else if (count_reg >= CW'(CAPACITY))
                                out_status_next = ST_FULL;
                            else
                            begin
                                wr_en     = 1'b1;
                                wr_addr   = count_reg[AW-1:0];
                                wr_key    = key_reg;
                                wr_value  = value_reg;
                                fin_count = count_reg + CW'(1);
                            end
                        end
                        ACT_ERASE:
                        begin
                            if (pos_x >= count_x)
                                out_status_next = ST_BAD_POSITION;
                            else
                                fin_count = count_reg - CW'(1);
                        end
                        ACT_LOOKUP:
                        begin
                            if (hit_reg)
                            begin
                                out_found_next = 1'b1;
                                out_value_next = VALUE_W'(hit_value_reg);
                            end
                            else
                                out_status_next = ST_NOT_FOUND;
                        end
                        default:
                            fin_count = '0;
                    endcase
                    fin_count_x    = (CW + COUNT_W)'(fin_count);
                    count_next     = fin_count;
                    out_count_next = fin_count_x[COUNT_W-1:0];
                    out_empty_next = (fin_count == '0);
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    // Pack result
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_empty_reg, out_count_reg, out_value_reg,
                       out_found_reg, out_status_reg};

endmodule

`default_nettype wire

// ----- design/ukv_chk.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ukv_chk
    import ukv_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [OUT_DATA_W-1:0] m_tdata
);

    // A stalled result stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // Empty flag agrees with the entry count
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[41] == (m_tdata[40:36] == 5'd0)))
        else $error("empty flag disagrees with count");

    // A hit always reports success
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3] |-> m_tdata[2:0] == ST_OK)
        else $error("hit with failing status");

    // No value without a hit
    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[3] |-> m_tdata[35:4] == 32'd0)
        else $error("value reported without a hit");

    // Status code in range
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[2:0] <= ST_NOT_FOUND)
        else $error("status code out of range");

endmodule

bind unique_key_value_table ukv_chk u_ukv_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
